@@ rtl/efr_pkg.sv @@
package efr_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_START_FLAG_ONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_FLAG_TWO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FLAG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_FLAG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD    = 3'd4;

    localparam logic [BYTE_W-1:0] RST_START_FLAG_ONE = 8'd170;
    localparam logic [BYTE_W-1:0] RST_START_FLAG_TWO = 8'd85;
    localparam logic [BYTE_W-1:0] RST_STOP_FLAG      = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_FLAG    = 8'd125;
    localparam logic [BYTE_W-1:0] RST_MAX_PAYLOAD    = 8'd64;

    typedef struct packed {
        logic [BYTE_W-1:0] start_flag_one;
        logic [BYTE_W-1:0] start_flag_two;
        logic [BYTE_W-1:0] stop_flag;
        logic [BYTE_W-1:0] escape_flag;
        logic [BYTE_W-1:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] src_addr;
        logic [BYTE_W-1:0] dst_addr;
        logic [WORD_W-1:0] seq_num;
        logic [BYTE_W-1:0] frame_length;
        logic [WORD_W-1:0] frame_crc;
    } result_t;

endpackage

@@ rtl/efr_cfg_regs.sv @@
module efr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [efr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [efr_pkg::BYTE_W-1:0]    wr_data,
    output efr_pkg::cfg_t                 cfg
);

    efr_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_flag_one <= efr_pkg::RST_START_FLAG_ONE;
            cfg_reg.start_flag_two <= efr_pkg::RST_START_FLAG_TWO;
            cfg_reg.stop_flag      <= efr_pkg::RST_STOP_FLAG;
            cfg_reg.escape_flag    <= efr_pkg::RST_ESCAPE_FLAG;
            cfg_reg.max_payload    <= efr_pkg::RST_MAX_PAYLOAD;
        end
        else if (wr_en)
        begin
            // drop writes to unknown indexes
            unique case (wr_index)
                efr_pkg::REG_START_FLAG_ONE: cfg_reg.start_flag_one <= wr_data;
                efr_pkg::REG_START_FLAG_TWO: cfg_reg.start_flag_two <= wr_data;
                efr_pkg::REG_STOP_FLAG:      cfg_reg.stop_flag      <= wr_data;
                efr_pkg::REG_ESCAPE_FLAG:    cfg_reg.escape_flag    <= wr_data;
                efr_pkg::REG_MAX_PAYLOAD:    cfg_reg.max_payload    <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/efr_core.sv @@
module efr_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  efr_pkg::cfg_t              cfg,
    input  logic                       fire,
    input  logic [efr_pkg::BYTE_W-1:0] rx,
    output efr_pkg::result_t           res
);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_START2,
        PH_SRC,
        PH_DST,
        PH_SEQ,
        PH_LEN,
        PH_DATA,
        PH_CRC,
        PH_STOP,
        PH_ERR
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic                        esc_reg, esc_next;
    logic [efr_pkg::BYTE_W-1:0]  count_reg, count_next;
    logic [efr_pkg::BYTE_W-1:0]  high_reg, high_next;
    logic [efr_pkg::BYTE_W-1:0]  src_reg, src_next;
    logic [efr_pkg::BYTE_W-1:0]  dst_reg, dst_next;
    logic [efr_pkg::WORD_W-1:0]  seq_reg, seq_next;
    logic [efr_pkg::BYTE_W-1:0]  len_reg, len_next;
    logic [efr_pkg::WORD_W-1:0]  crc_reg, crc_next;

    logic                        take_data;
    logic                        emit;
    logic                        complete;
    logic [efr_pkg::BYTE_W-1:0]  count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        count_next = count_reg;
        high_next  = high_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        take_data  = 1'b0;
        emit       = 1'b0;
        complete   = 1'b0;

        // a byte after an escape is data; else flag priority: first start, second start, stop, escape
        if (esc_reg)
        begin
            esc_next  = 1'b0;
            take_data = 1'b1;
        end
        else if (rx == cfg.start_flag_one)
        begin
            phase_next = PH_START2;
            count_next = '0;
        end
        else if (rx == cfg.start_flag_two)
        begin
            phase_next = (phase_reg == PH_START2) ? PH_SRC : PH_ERR;
        end
        else if (rx == cfg.stop_flag)
        begin
            if (phase_reg == PH_STOP)
            begin
                phase_next = PH_HUNT;
                complete   = 1'b1;
            end
            else
            begin
                phase_next = PH_ERR;
            end
        end
        else if (rx == cfg.escape_flag)
        begin
            if (phase_reg != PH_ERR)
                esc_next = 1'b1;
        end
        else
        begin
            take_data = 1'b1;
        end

        if (take_data)
        begin
            unique case (phase_reg)
                PH_SRC:
                begin
                    src_next   = rx;
                    phase_next = PH_DST;
                end
                PH_DST:
                begin
                    dst_next   = rx;
                    phase_next = PH_SEQ;
                    count_next = '0;
                end
                PH_SEQ:
                begin
                    if (count_reg == '0)
                    begin
                        high_next  = rx;
                        count_next = 8'd1;
                    end
                    else
                    begin
                        seq_next   = {high_reg, rx};
                        count_next = '0;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    len_next   = rx;
                    count_next = '0;
                    if (rx > cfg.max_payload)
                        phase_next = PH_ERR;
                    else if (rx == '0)
                        phase_next = PH_CRC;
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    emit = 1'b1;
                    if (count_inc >= len_reg)
                    begin
                        count_next = '0;
                        phase_next = PH_CRC;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_CRC:
                begin
                    if (count_reg == '0)
                    begin
                        high_next  = rx;
                        count_next = 8'd1;
                    end
                    else
                    begin
                        crc_next   = {high_reg, rx};
                        count_next = '0;
                        phase_next = PH_STOP;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res = '0;
        if (emit)
        begin
            res.kind          = efr_pkg::KIND_PAYLOAD;
            res.payload_byte  = rx;
            res.payload_index = count_reg;
        end
        else if (complete)
        begin
            res.kind         = efr_pkg::KIND_COMPLETE;
            res.src_addr     = src_reg;
            res.dst_addr     = dst_reg;
            res.seq_num      = seq_reg;
            res.frame_length = len_reg;
            res.frame_crc    = crc_reg;
        end
        else if (phase_next == PH_ERR)
        begin
            res.kind = efr_pkg::KIND_ERROR;
        end
        else
        begin
            res.kind = efr_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            esc_reg   <= 1'b0;
            count_reg <= '0;
            high_reg  <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            crc_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            count_reg <= count_next;
            high_reg  <= high_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

@@ rtl/escaped_frame_receiver_unit.sv @@
// Byte-stuffed frame receiver: takes one raw link byte per item and returns one
// result item per byte (nothing, payload byte with index, frame complete with
// header and CRC, or error). An item passes an input register and a result
// register; a new byte is taken every cycle unless the output stalls, and
// the frame state update between the two registers sets that rate. The flag
// and limit registers reset to 170/85/126/125/64 and are written through the
// config port, by the user only while no item is in flight (the block does not check).
module escaped_frame_receiver_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [efr_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [efr_pkg::KIND_W-1:0]    kind,
    output logic [efr_pkg::BYTE_W-1:0]    payload_byte,
    output logic [efr_pkg::BYTE_W-1:0]    payload_index,
    output logic [efr_pkg::BYTE_W-1:0]    src_addr,
    output logic [efr_pkg::BYTE_W-1:0]    dst_addr,
    output logic [efr_pkg::WORD_W-1:0]    seq_num,
    output logic [efr_pkg::BYTE_W-1:0]    frame_length,
    output logic [efr_pkg::WORD_W-1:0]    frame_crc,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [efr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [efr_pkg::BYTE_W-1:0]    cfg_data
);

    efr_pkg::cfg_t              cfg;
    efr_pkg::result_t           res;
    efr_pkg::result_t           res_reg;
    logic                       s1_valid_reg;
    logic [efr_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                       out_valid_reg;
    logic                       out_free;
    logic                       advance;
    logic                       in_take;

    assign cfg_ready = 1'b1;

    efr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    efr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (advance),
        .rx    (s1_byte_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_byte_reg <= rx_byte;
        if (advance)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = res_reg.kind;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_index = res_reg.payload_index;
    assign src_addr      = res_reg.src_addr;
    assign dst_addr      = res_reg.dst_addr;
    assign seq_num       = res_reg.seq_num;
    assign frame_length  = res_reg.frame_length;
    assign frame_crc     = res_reg.frame_crc;

endmodule
